[hdl/sliding_window_median_filter_unit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sliding window median filter
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEDIAN_FILTER_UNIT_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_FILTER_UNIT_DEFINES_SVH

// same-cycle implication
`define SWMF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SWMF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/swmf_pkg.sv]
// ----------------------------------------------------------------------------
// Median filter package
// Shared constants and the control group driven into the sort cells.
// ----------------------------------------------------------------------------
`default_nettype none

package swmf_pkg;

    localparam int CFG_W   = 5;
    localparam int CFG_RST = 3;

    typedef struct packed {
        logic clear;
        logic insert;
        logic shift;
    } t_cell_ctrl;

endpackage

`default_nettype wire

[hdl/swmf_ifs.sv]
// ----------------------------------------------------------------------------
// Median filter channels
// Valid/ready channels for samples, results and the window size register.
// ----------------------------------------------------------------------------
`default_nettype none

interface swmf_smp_if #(
    parameter int SAMPLE_WIDTH = 16
) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface swmf_med_if #(
    parameter int SAMPLE_WIDTH = 16
) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] median;

    modport source (output valid, output median, input ready);
    modport sink   (input valid, input median, output ready);
endinterface

interface swmf_cfg_if
    import swmf_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] window_size;

    modport source (output valid, output window_size, input ready);
    modport sink   (input valid, input window_size, output ready);
endinterface

`default_nettype wire

[hdl/sliding_window_median_filter_unit.sv]
// ----------------------------------------------------------------------------
// Sliding window median filter
// Running median over the newest window_size samples of a block. For an
// item with a result, the newest samples are fed one per cycle into a chain
// of sorted insertion cells, the chain then shifts the middle entries down to
// cell 0, and the median is registered. The output register lets the next
// sample in while a result waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_median_filter_unit
    import swmf_pkg::*;
#(
    parameter int WINDOW_MAX   = 16,
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    swmf_smp_if.sink   i_smp,
    swmf_med_if.source o_med,
    swmf_cfg_if.sink   i_cfg
);

`include "sliding_window_median_filter_unit_defines.svh"

    localparam int CW     = $clog2(WINDOW_MAX + 1);
    localparam int EW     = (CW > CFG_W) ? CW : CFG_W;
    localparam int RST_WS = (CFG_RST > WINDOW_MAX) ? WINDOW_MAX : CFG_RST;
    localparam int SEC    = (WINDOW_MAX > 1) ? 1 : 0;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SORT = 4'b0010,
        S_PICK = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [CW-1:0] r_ws;
    logic [CW-1:0] r_fill, n_fill;
    logic [CW-1:0] r_k;
    logic [CW-1:0] r_j;
    logic [CW-1:0] w_t;
    logic [CW-1:0] w_ws_m1;
    logic [EW-1:0] w_cfg_ext;
    logic [EW-1:0] w_cfg_eff;

    logic signed [SAMPLE_WIDTH-1:0] r_age  [WINDOW_MAX];
    logic signed [SAMPLE_WIDTH-1:0] r_feed [WINDOW_MAX];

    logic signed [SAMPLE_WIDTH-1:0] w_val [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]          w_vld;
    logic [WINDOW_MAX-1:0]          w_gt;
    t_cell_ctrl                     w_ctrl;

    logic                           r_out_vld;
    logic signed [SAMPLE_WIDTH-1:0] r_med;
    logic signed [SAMPLE_WIDTH:0]   w_sum;
    logic signed [SAMPLE_WIDTH-1:0] w_med;

    logic w_acc;
    logic w_take;
    logic w_produce;
    logic w_load_out;

    // configuration
    assign i_cfg.ready = 1'b1;
    assign w_cfg_ext   = EW'(i_cfg.window_size);
    assign w_cfg_eff   = (i_cfg.window_size == '0) ? EW'(1) :
                         ((w_cfg_ext > EW'(WINDOW_MAX)) ? EW'(WINDOW_MAX) : w_cfg_ext);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws <= CW'(RST_WS);
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_ws <= w_cfg_eff[CW-1:0];
        end
    end

    // handshakes
    assign i_smp.ready  = (r_state == S_IDLE);
    assign w_acc        = i_smp.valid && i_smp.ready;
    assign w_take       = o_med.valid && o_med.ready;
    assign o_med.valid  = r_out_vld;
    assign o_med.median = r_med;

    assign n_fill    = (r_fill == CW'(WINDOW_MAX)) ? r_fill : r_fill + CW'(1);
    assign w_produce = (n_fill >= r_ws);
    assign w_ws_m1   = r_ws - CW'(1);
    assign w_t       = w_ws_m1 >> 1;
    assign w_load_out = (r_state == S_OUT) && (!r_out_vld || o_med.ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc && w_produce) begin
                    n_state = S_SORT;
                end
            end
            S_SORT: begin
                if (r_k == w_ws_m1) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                if (r_j == w_t) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_k     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            if (w_acc) begin
                r_fill <= i_smp.last_sample ? '0 : n_fill;
                r_k    <= '0;
                r_j    <= '0;
            end
            if (r_state == S_SORT) begin
                r_k <= r_k + CW'(1);
            end
            if (r_state == S_PICK && r_j != w_t) begin
                r_j <= r_j + CW'(1);
            end
        end
    end

    // age line (newest at 0) and feed line
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_age[0]  <= i_smp.sample;
            r_feed[0] <= i_smp.sample;
            for (int i = 1; i < WINDOW_MAX; i++) begin
                r_age[i]  <= r_age[i-1];
                r_feed[i] <= r_age[i-1];
            end
        end else if (r_state == S_SORT) begin
            for (int i = 0; i < WINDOW_MAX - 1; i++) begin
                r_feed[i] <= r_feed[i+1];
            end
        end
    end

    // sorted cell chain
    assign w_ctrl.clear  = w_acc;
    assign w_ctrl.insert = (r_state == S_SORT);
    assign w_ctrl.shift  = (r_state == S_PICK) && (r_j != w_t);

    for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
        logic signed [SAMPLE_WIDTH-1:0] w_pv;
        logic signed [SAMPLE_WIDTH-1:0] w_nv;
        logic                           w_pvld;
        logic                           w_pgt;
        logic                           w_nvld;

        if (g == 0) begin : g_head
            assign w_pv   = r_feed[0];
            assign w_pvld = 1'b1;
            assign w_pgt  = 1'b0;
        end else begin : g_body
            assign w_pv   = w_val[g-1];
            assign w_pvld = w_vld[g-1];
            assign w_pgt  = w_gt[g-1];
        end

        if (g == WINDOW_MAX - 1) begin : g_tail
            assign w_nv   = '0;
            assign w_nvld = 1'b0;
        end else begin : g_mid
            assign w_nv   = w_val[g+1];
            assign w_nvld = w_vld[g+1];
        end

        swmf_sort_cell #(
            .SAMPLE_WIDTH(SAMPLE_WIDTH)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (w_ctrl),
            .i_new      (r_feed[0]),
            .i_prev_val (w_pv),
            .i_prev_vld (w_pvld),
            .i_prev_gt  (w_pgt),
            .i_next_val (w_nv),
            .i_next_vld (w_nvld),
            .o_val      (w_val[g]),
            .o_vld      (w_vld[g]),
            .o_gt       (w_gt[g])
        );
    end

    // median: odd window takes cell 0, even window floors the mean of cells 0 and 1
    assign w_sum = {w_val[0][SAMPLE_WIDTH-1], w_val[0]}
                 + {w_val[SEC][SAMPLE_WIDTH-1], w_val[SEC]};
    assign w_med = r_ws[0] ? w_val[0] : w_sum[SAMPLE_WIDTH:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_load_out) begin
            r_out_vld <= 1'b1;
        end else if (w_take) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_med <= w_med;
        end
    end

    `SWMF_ASSERT_IMP(a_sort_count, (r_state == S_SORT), ($countones(w_vld) == int'(r_k)), "sort chain fill does not match insert count")
    `SWMF_ASSERT_IMP(a_pick_full, ((r_state == S_PICK) && (r_j == '0)), ($countones(w_vld) == int'(r_ws)), "sort chain does not hold the full window")
    `SWMF_ASSERT_IMP(a_out_src, $rose(r_out_vld), ($past(r_state) == S_OUT), "result appeared outside the output step")
    `SWMF_ASSERT_NXT(a_acc_next, w_acc, ((r_state == S_IDLE) || (r_state == S_SORT)), "bad state after a sample transfer")

endmodule

`default_nettype wire

[hdl/swmf_sort_cell.sv]
// ----------------------------------------------------------------------------
// Median filter sort cell
// One slot of the sorted insertion chain; can also shift toward cell 0.
// ----------------------------------------------------------------------------
`default_nettype none

module swmf_sort_cell
    import swmf_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire t_cell_ctrl               i_ctrl,
    input  wire signed [SAMPLE_WIDTH-1:0] i_new,
    input  wire signed [SAMPLE_WIDTH-1:0] i_prev_val,
    input  wire                           i_prev_vld,
    input  wire                           i_prev_gt,
    input  wire signed [SAMPLE_WIDTH-1:0] i_next_val,
    input  wire                           i_next_vld,
    output logic signed [SAMPLE_WIDTH-1:0] o_val,
    output logic                          o_vld,
    output logic                          o_gt
);

    logic signed [SAMPLE_WIDTH-1:0] r_val;
    logic                           r_vld;

    // new value belongs at or before this slot
    assign o_gt  = !r_vld || (r_val > i_new);
    assign o_val = r_val;
    assign o_vld = r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_vld <= 1'b0;
        end else if (i_ctrl.insert) begin
            if (o_gt) begin
                r_vld <= i_prev_gt ? i_prev_vld : 1'b1;
            end
        end else if (i_ctrl.shift) begin
            r_vld <= i_next_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.insert && !i_ctrl.clear) begin
            if (o_gt) begin
                r_val <= i_prev_gt ? i_prev_val : i_new;
            end
        end else if (i_ctrl.shift && !i_ctrl.clear) begin
            r_val <= i_next_val;
        end
    end

endmodule

`default_nettype wire
